// ===== src/cst_pkg.sv =====
`default_nettype none

package cst_pkg;

	localparam int unsigned YEAR_WIDTH_DEF = 16;
	localparam int unsigned LOAD_YEAR_W    = 16;
	localparam int unsigned IN_DATA_W      = 48;
	localparam int unsigned OUT_DATA_W     = 48;

	localparam logic [6:0] SEC_LIMIT   = 7'd60;
	localparam logic [6:0] MIN_LIMIT   = 7'd60;
	localparam logic [5:0] HOUR_MAX    = 6'd23;
	localparam logic [4:0] MONTH_MAX   = 5'd11;
	localparam logic [4:0] FIRST_DAY   = 5'd1;
	localparam logic [4:0] LONG_MONTH  = 5'd31;
	localparam logic [4:0] LEAP_FEB    = 5'd29;
	localparam logic [3:0] FEBRUARY    = 4'd1;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_t;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		if (month > MONTH_MAX[3:0]) begin
			len = LONG_MONTH;
		end else if (month == FEBRUARY && leap) begin
			len = LEAP_FEB;
		end else begin
			len = MONTH_LEN[month];
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== src/cst_step.sv =====
`default_nettype none

module cst_step #(
	parameter int unsigned YEAR_WIDTH = cst_pkg::YEAR_WIDTH_DEF
) (
	input  wire cst_pkg::opcode_t                 op,
	input  wire cst_pkg::cal_t                    ld,
	input  wire [cst_pkg::LOAD_YEAR_W-1:0]        ld_year,
	input  wire cst_pkg::cal_t                    cur,
	input  wire [YEAR_WIDTH-1:0]                  cur_year,
	output cst_pkg::cal_t                         nxt,
	output logic [YEAR_WIDTH-1:0]                 nxt_year
);

	logic [6:0] sec_inc, min_inc;
	logic [5:0] hour_inc, day_inc;
	logic [4:0] mon_inc, len;
	logic       c_sec, c_min, c_hour, c_day, c_mon, leap;
	cst_pkg::cal_t tick;
	logic [YEAR_WIDTH-1:0] tick_year;

	always_comb begin
		// carry chain; each stage is tested whether or not the one below carried
		leap    = (cur_year[1:0] == 2'b00);
		sec_inc = {1'b0, cur.second} + 7'd1;
		c_sec   = (sec_inc >= cst_pkg::SEC_LIMIT);
		min_inc = {1'b0, cur.minute} + {6'd0, c_sec};
		c_min   = (min_inc >= cst_pkg::MIN_LIMIT);
		hour_inc = {1'b0, cur.hour} + {5'd0, c_min};
		c_hour  = (hour_inc > cst_pkg::HOUR_MAX);
		day_inc = {1'b0, cur.day} + {5'd0, c_hour};
		len     = cst_pkg::month_days(cur.month, leap);
		c_day   = (day_inc > {1'b0, len});
		mon_inc = {1'b0, cur.month} + {4'd0, c_day};
		c_mon   = (mon_inc > cst_pkg::MONTH_MAX);

		tick.second = c_sec  ? 6'd0 : sec_inc[5:0];
		tick.minute = c_min  ? 6'd0 : min_inc[5:0];
		tick.hour   = c_hour ? 5'd0 : hour_inc[4:0];
		tick.day    = c_day  ? cst_pkg::FIRST_DAY : day_inc[4:0];
		tick.month  = c_mon  ? 4'd0 : mon_inc[3:0];
		tick_year   = cur_year + YEAR_WIDTH'(c_mon);

		if (op == cst_pkg::OP_LOAD) begin
			nxt      = ld;
			nxt_year = YEAR_WIDTH'(ld_year);
		end else begin
			nxt      = tick;
			nxt_year = tick_year;
		end
	end

endmodule

`default_nettype wire

// ===== src/calendar_second_tick_core.sv =====
// Calendar counter: second, minute, hour, day of month, month and year.
// Slave channel: each item is a one-second tick (tuser = 0) or a load of the
// full date and time (tuser = 1, fields in tdata). Master channel: one item
// per input item, holding the fields after that item plus the leap flag.
// An accepted item is held in the input register, then in the calendar/result
// register, which drives m_tvalid. Throughput: one item per cycle while the
// receiver keeps m_tready high; the whole carry chain from seconds to year is
// worked out combinationally between the input and calendar/result registers.
// The input register lets one item be taken while a result waits; when the
// receiver holds m_tready low, the input register fills and s_tready drops
// until the result is taken. No item is lost or repeated.
// Reset: the time reads 00:00:00, day 1, month 0 (January), year 0; both
// valid flags clear. Loaded values are taken as given; the year wraps at
// YEAR_WIDTH bits and tdata carries its low 16 bits.
`default_nettype none

module calendar_second_tick_core #(
	parameter int unsigned YEAR_WIDTH = cst_pkg::YEAR_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// load_second, load_minute, load_hour, load_day, load_month, load_year, zero pad
	input  wire [cst_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// second_now, minute_now, hour_now, day_now, month_now, year_now, leap_now, zero pad
	output logic [cst_pkg::OUT_DATA_W-1:0]   m_tdata
);

	logic                                  v_s1;
	cst_pkg::opcode_t                      op_s1;
	cst_pkg::cal_t                         ld_s1;
	logic [cst_pkg::LOAD_YEAR_W-1:0]       ld_year_s1;
	logic                                  out_v_q;
	cst_pkg::cal_t                         cal_q;
	logic [YEAR_WIDTH-1:0]                 year_q;
	cst_pkg::cal_t                         cal_nxt;
	logic [YEAR_WIDTH-1:0]                 year_nxt;
	logic                                  adv, take;

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1      <= cst_pkg::opcode_t'(s_tuser);
			ld_s1      <= '{second: s_tdata[5:0], minute: s_tdata[11:6],
				hour: s_tdata[16:12], day: s_tdata[21:17], month: s_tdata[25:22]};
			ld_year_s1 <= s_tdata[41:26];
		end
	end

	cst_step #(
		.YEAR_WIDTH(YEAR_WIDTH)
	) u_step (
		.op       (op_s1),
		.ld       (ld_s1),
		.ld_year  (ld_year_s1),
		.cur      (cal_q),
		.cur_year (year_q),
		.nxt      (cal_nxt),
		.nxt_year (year_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cal_q   <= '{second: 6'd0, minute: 6'd0, hour: 5'd0,
				day: cst_pkg::FIRST_DAY, month: 4'd0};
			year_q  <= '0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
				cal_q   <= cal_nxt;
				year_q  <= year_nxt;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, (year_q[1:0] == 2'b00), 16'(year_q), cal_q.month, cal_q.day,
		cal_q.hour, cal_q.minute, cal_q.second};

`ifndef SYNTHESIS
	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == cst_pkg::OP_TICK |=> cal_q.second < 6'd60 && cal_q.minute < 6'd60
			&& cal_q.hour < 5'd24 && cal_q.month < 4'd12)
		else $error("calendar fields out of range after a tick");

	a_load_taken: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == cst_pkg::OP_LOAD |=> cal_q == $past(ld_s1)
			&& year_q == YEAR_WIDTH'($past(ld_year_s1)))
		else $error("loaded fields not stored");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && out_v_q && !m_tready)
		else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
